// ===== sv/lctvl_pkg.sv =====
// ----------------------------------------------------------------------------
// lctvl_pkg: shared types and constants of the tank volume linearizer
// Holds the field widths, the register indexes, the register reset values and
// the fixed points of the calibration curve.
// ----------------------------------------------------------------------------
package lctvl_pkg;

    // Field widths
    localparam int CUR_W    = 15;
    localparam int MM_W     = 14;
    localparam int VOL_W    = 16;
    localparam int PCT_W    = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Register indexes on the configuration channel
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_CURRENT  = 3'd0,
        CFG_CURRENT_SPAN = 3'd1,
        CFG_SENSOR_RANGE = 3'd2,
        CFG_MAX_HEIGHT   = 3'd3,
        CFG_USABLE_VOL   = 3'd4
    } t_cfg_idx;

    // Register reset values
    localparam logic [CUR_W-1:0] RST_MIN_CURRENT  = 15'd4000;
    localparam logic [CUR_W-1:0] RST_CURRENT_SPAN = 15'd16000;
    localparam logic [MM_W-1:0]  RST_SENSOR_RANGE = 14'd2500;
    localparam logic [MM_W-1:0]  RST_MAX_HEIGHT   = 14'd2000;
    localparam logic [VOL_W-1:0] RST_USABLE_VOL   = 16'd7000;

    // Fixed curve points (height mm, volume l); the first point is the origin
    localparam logic [MM_W-1:0]  CURVE_H1 = 14'd708;
    localparam logic [MM_W-1:0]  CURVE_H2 = 14'd874;
    localparam logic [MM_W-1:0]  CURVE_H3 = 14'd1168;
    localparam logic [VOL_W-1:0] CURVE_V1 = 16'd2450;
    localparam logic [VOL_W-1:0] CURVE_V2 = 16'd3200;
    localparam logic [VOL_W-1:0] CURVE_V3 = 16'd4550;

    // Full scale of a percentage in tenths
    localparam logic [PCT_W-1:0] PCT_FULL = 10'd1000;

endpackage

// ===== sv/lctvl_div_cell.sv =====
// ----------------------------------------------------------------------------
// lctvl_div_cell: one restoring division step
// Takes one dividend bit into the partial remainder, subtracts the divisor
// where it fits and shifts the quotient bit in. Registers the result.
// ----------------------------------------------------------------------------
module lctvl_div_cell #(
    parameter int DW = 14,
    parameter int QW = 10,
    parameter int TW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_rem,
    input  logic [QW-1:0] i_word,
    input  logic [DW-1:0] i_div,
    input  logic [TW-1:0] i_tag,
    output logic          o_valid,
    output logic [DW-1:0] o_rem,
    output logic [QW-1:0] o_word,
    output logic [DW-1:0] o_div,
    output logic [TW-1:0] o_tag
);

    logic          r_valid;
    logic [DW-1:0] r_rem;
    logic [QW-1:0] r_word;
    logic [DW-1:0] r_div;
    logic [TW-1:0] r_tag;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          fits;
    logic [DW-1:0] n_rem;
    logic [QW-1:0] n_word;

    // Trial subtract of the divisor from the shifted remainder
    always_comb begin
        trial  = {i_rem, i_word[QW-1]};
        diff   = trial - {1'b0, i_div};
        fits   = (trial >= {1'b0, i_div});
        n_rem  = fits ? diff[DW-1:0] : trial[DW-1:0];
        n_word = {i_word[QW-2:0], fits};
    end

    // Clear the valid flag in reset, advance it when enabled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Advance the working word
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_word <= n_word;
            r_div  <= i_div;
            r_tag  <= i_tag;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_word  = r_word;
    assign o_div   = r_div;
    assign o_tag   = r_tag;

endmodule

// ===== sv/lctvl_div_chain.sv =====
// ----------------------------------------------------------------------------
// lctvl_div_chain: pipelined unsigned divider
// A row of QW division cells, one quotient bit per cell. The dividend must be
// below the divisor shifted up by QW bits. A tag travels alongside.
// ----------------------------------------------------------------------------
module lctvl_div_chain #(
    parameter int DW = 14,
    parameter int QW = 10,
    parameter int TW = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [DW+QW-1:0] i_dividend,
    input  logic [DW-1:0]    i_div,
    input  logic [TW-1:0]    i_tag,
    output logic             o_valid,
    output logic [QW-1:0]    o_quot,
    output logic [TW-1:0]    o_tag
);

    logic          c_valid [QW+1];
    logic [DW-1:0] c_rem   [QW+1];
    logic [QW-1:0] c_word  [QW+1];
    logic [DW-1:0] c_div   [QW+1];
    logic [TW-1:0] c_tag   [QW+1];

    // Split the dividend into starting remainder and shifted-in bits
    assign c_valid[0] = i_valid;
    assign c_rem[0]   = i_dividend[DW+QW-1:QW];
    assign c_word[0]  = i_dividend[QW-1:0];
    assign c_div[0]   = i_div;
    assign c_tag[0]   = i_tag;

    for (genvar k = 0; k < QW; k++) begin : g_cell
        lctvl_div_cell #(
            .DW (DW),
            .QW (QW),
            .TW (TW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (c_valid[k]),
            .i_rem   (c_rem[k]),
            .i_word  (c_word[k]),
            .i_div   (c_div[k]),
            .i_tag   (c_tag[k]),
            .o_valid (c_valid[k+1]),
            .o_rem   (c_rem[k+1]),
            .o_word  (c_word[k+1]),
            .o_div   (c_div[k+1]),
            .o_tag   (c_tag[k+1])
        );
    end

    assign o_valid = c_valid[QW];
    assign o_quot  = c_word[QW];
    assign o_tag   = c_tag[QW];

endmodule

// ===== sv/loop_current_tank_volume_linearizer_unit.sv =====
// ----------------------------------------------------------------------------
// loop_current_tank_volume_linearizer_unit: loop current to level and volume
// Maps a loop-current sample to water level, level percentage, volume from a
// five-point piecewise-linear curve, and volume percentage.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------
//  in      | sink      | i_in_valid / o_in_ready   | i_current_ua
//  out     | source    | o_out_valid / i_out_ready | o_level_mm, o_height_
//          |           |                           | tenth_pct, o_volume_l,
//          |           |                           | o_volume_tenth_pct
//  cfg     | sink      | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  One beat per cycle in while the pipeline is not stalled; a beat passes
//  through four rows of division cells (14, 10, 16 and 10 quotient bits) plus
//  the registers around them. The whole pipeline advances together whenever
//  the output register is empty or being taken; a stall holds every stage.
//  Synchronous active-low reset clears all valid flags and loads the register
//  reset values. Configuration is taken in any cycle.
//
module loop_current_tank_volume_linearizer_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [lctvl_pkg::CUR_W-1:0]          i_current_ua,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [lctvl_pkg::MM_W-1:0]           o_level_mm,
    output logic [lctvl_pkg::PCT_W-1:0]          o_height_tenth_pct,
    output logic [lctvl_pkg::VOL_W-1:0]          o_volume_l,
    output logic [lctvl_pkg::PCT_W-1:0]          o_volume_tenth_pct,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [lctvl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lctvl_pkg::CFG_DAT_W-1:0]      i_cfg_data
);

    import lctvl_pkg::*;

    localparam int TAG1_W = 2;
    localparam int TAGH_W = MM_W + 2;
    localparam int TAGV_W = MM_W + PCT_W + 1 + VOL_W;
    localparam int TAGP_W = MM_W + PCT_W + VOL_W + 2;

    // Configuration registers
    logic [CUR_W-1:0] r_min;
    logic [CUR_W-1:0] r_span;
    logic [MM_W-1:0]  r_range;
    logic [MM_W-1:0]  r_max;
    logic [VOL_W-1:0] r_usable;

    logic en;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min    <= RST_MIN_CURRENT;
            r_span   <= RST_CURRENT_SPAN;
            r_range  <= RST_SENSOR_RANGE;
            r_max    <= RST_MAX_HEIGHT;
            r_usable <= RST_USABLE_VOL;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MIN_CURRENT:  r_min    <= i_cfg_data[CUR_W-1:0];
                CFG_CURRENT_SPAN: r_span   <= i_cfg_data[CUR_W-1:0];
                CFG_SENSOR_RANGE: r_range  <= i_cfg_data[MM_W-1:0];
                CFG_MAX_HEIGHT:   r_max    <= i_cfg_data[MM_W-1:0];
                CFG_USABLE_VOL:   r_usable <= i_cfg_data[VOL_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // ---------------------------------------------------------------- stage A
    logic             r_a_valid;
    logic [CUR_W-1:0] r_a_cur;

    // Capture the input beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_cur <= i_current_ua;
        end
    end

    // ---------------------------------------------------------------- stage B
    logic [CUR_W-1:0]      a_diff;
    logic                  n_b_zero;
    logic                  n_b_sat;
    logic [CUR_W+MM_W-1:0] n_b_prod;
    logic                  r_b_valid;
    logic                  r_b_zero;
    logic                  r_b_sat;
    logic [CUR_W+MM_W-1:0] r_b_prod;

    // Offset from minimum current and scaled product
    always_comb begin
        a_diff   = r_a_cur - r_min;
        n_b_zero = (r_a_cur <= r_min);
        n_b_sat  = (a_diff >= r_span);
        n_b_prod = (CUR_W+MM_W)'(a_diff) * (CUR_W+MM_W)'(r_range);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_zero <= n_b_zero;
            r_b_sat  <= n_b_sat;
            r_b_prod <= n_b_prod;
        end
    end

    // Level quotient: offset * range / span
    logic              d1_valid;
    logic [MM_W-1:0]   d1_quot;
    logic [TAG1_W-1:0] d1_tag;

    lctvl_div_chain #(
        .DW (CUR_W),
        .QW (MM_W),
        .TW (TAG1_W)
    ) u_div_level (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_b_valid),
        .i_dividend (r_b_prod),
        .i_div      (r_span),
        .i_tag      ({r_b_zero, r_b_sat}),
        .o_valid    (d1_valid),
        .o_quot     (d1_quot),
        .o_tag      (d1_tag)
    );

    // ---------------------------------------------------------------- stage C
    logic            r_c_valid;
    logic [MM_W-1:0] r_c_level;
    logic [MM_W-1:0] n_c_level;

    // Clamp the level to zero or full range
    always_comb begin
        if (d1_tag[1]) begin
            n_c_level = '0;
        end else if (d1_tag[0]) begin
            n_c_level = r_range;
        end else begin
            n_c_level = d1_quot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_c_valid <= d1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_level <= n_c_level;
        end
    end

    // Height percentage: saturate where level reaches maximum height
    logic                 c_hfull;
    logic                 c_hzero;
    logic [MM_W+PCT_W-1:0] c_hprod;

    always_comb begin
        if (r_max == '0) begin
            c_hfull = (r_c_level != '0);
            c_hzero = (r_c_level == '0);
        end else begin
            c_hfull = (r_c_level >= r_max);
            c_hzero = 1'b0;
        end
        c_hprod = (MM_W+PCT_W)'(r_c_level) * (MM_W+PCT_W)'(PCT_FULL);
    end

    logic              dh_valid;
    logic [PCT_W-1:0]  dh_quot;
    logic [TAGH_W-1:0] dh_tag;

    lctvl_div_chain #(
        .DW (MM_W),
        .QW (PCT_W),
        .TW (TAGH_W)
    ) u_div_height (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_c_valid),
        .i_dividend (c_hprod),
        .i_div      (r_max),
        .i_tag      ({r_c_level, c_hfull, c_hzero}),
        .o_valid    (dh_valid),
        .o_quot     (dh_quot),
        .o_tag      (dh_tag)
    );

    // --------------------------------------------------------------- stage D1
    logic [MM_W-1:0]  h_level;
    logic [PCT_W-1:0] h_pct;
    logic [MM_W-1:0]  h_lv;
    logic [MM_W-1:0]  h_h0;
    logic [VOL_W-1:0] n_d_v0;
    logic [VOL_W-1:0] n_d_dv;
    logic             n_d_neg;
    logic [MM_W-1:0]  n_d_dh;

    // Select the curve segment for the clamped level
    always_comb begin
        h_level = dh_tag[TAGH_W-1:2];
        if (dh_tag[1]) begin
            h_pct = PCT_FULL;
        end else if (dh_tag[0]) begin
            h_pct = '0;
        end else begin
            h_pct = dh_quot;
        end
        h_lv    = (h_level > r_max) ? r_max : h_level;
        n_d_neg = 1'b0;
        if (h_lv <= CURVE_H1) begin
            h_h0   = '0;
            n_d_v0 = '0;
            n_d_dv = CURVE_V1;
            n_d_dh = CURVE_H1;
        end else if (h_lv <= CURVE_H2) begin
            h_h0   = CURVE_H1;
            n_d_v0 = CURVE_V1;
            n_d_dv = CURVE_V2 - CURVE_V1;
            n_d_dh = CURVE_H2 - CURVE_H1;
        end else if (h_lv <= CURVE_H3) begin
            h_h0   = CURVE_H2;
            n_d_v0 = CURVE_V2;
            n_d_dv = CURVE_V3 - CURVE_V2;
            n_d_dh = CURVE_H3 - CURVE_H2;
        end else begin
            h_h0   = CURVE_H3;
            n_d_v0 = CURVE_V3;
            n_d_dh = r_max - CURVE_H3;
            if (r_usable >= CURVE_V3) begin
                n_d_dv = r_usable - CURVE_V3;
            end else begin
                n_d_dv  = CURVE_V3 - r_usable;
                n_d_neg = 1'b1;
            end
        end
    end

    logic             r_d_valid;
    logic [MM_W-1:0]  r_d_level;
    logic [PCT_W-1:0] r_d_hpct;
    logic [MM_W-1:0]  r_d_off;
    logic [VOL_W-1:0] r_d_dv;
    logic             r_d_neg;
    logic [VOL_W-1:0] r_d_v0;
    logic [MM_W-1:0]  r_d_dh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (en) begin
            r_d_valid <= dh_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_level <= h_level;
            r_d_hpct  <= h_pct;
            r_d_off   <= h_lv - h_h0;
            r_d_dv    <= n_d_dv;
            r_d_neg   <= n_d_neg;
            r_d_v0    <= n_d_v0;
            r_d_dh    <= n_d_dh;
        end
    end

    // --------------------------------------------------------------- stage D2
    logic                   r_e_valid;
    logic [MM_W+VOL_W-1:0]  r_e_prod;
    logic [MM_W-1:0]        r_e_dh;
    logic [TAGV_W-1:0]      r_e_tag;

    // Multiply segment offset by volume rise
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (en) begin
            r_e_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_prod <= (MM_W+VOL_W)'(r_d_off) * (MM_W+VOL_W)'(r_d_dv);
            r_e_dh   <= r_d_dh;
            r_e_tag  <= {r_d_level, r_d_hpct, r_d_neg, r_d_v0};
        end
    end

    logic              dv_valid;
    logic [VOL_W-1:0]  dv_quot;
    logic [TAGV_W-1:0] dv_tag;

    lctvl_div_chain #(
        .DW (MM_W),
        .QW (VOL_W),
        .TW (TAGV_W)
    ) u_div_volume (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_e_valid),
        .i_dividend (r_e_prod),
        .i_div      (r_e_dh),
        .i_tag      (r_e_tag),
        .o_valid    (dv_valid),
        .o_quot     (dv_quot),
        .o_tag      (dv_tag)
    );

    // ---------------------------------------------------------------- stage F
    logic [VOL_W+1:0]       v_sum;
    logic [VOL_W-1:0]       v_v0;
    logic [VOL_W-1:0]       n_f_vol;
    logic                   n_f_full;
    logic                   n_f_zero;

    // Add or subtract the segment rise, clamp at zero
    always_comb begin
        v_v0 = dv_tag[VOL_W-1:0];
        if (dv_tag[VOL_W]) begin
            v_sum = {2'b00, v_v0} - {2'b00, dv_quot};
        end else begin
            v_sum = {2'b00, v_v0} + {2'b00, dv_quot};
        end
        n_f_vol = v_sum[VOL_W+1] ? '0 : v_sum[VOL_W-1:0];
        if (r_usable == '0) begin
            n_f_full = (n_f_vol != '0);
            n_f_zero = (n_f_vol == '0);
        end else begin
            n_f_full = (n_f_vol >= r_usable);
            n_f_zero = 1'b0;
        end
    end

    logic                   r_f_valid;
    logic [VOL_W+PCT_W-1:0] r_f_prod;
    logic [TAGP_W-1:0]      r_f_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (en) begin
            r_f_valid <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_prod <= (VOL_W+PCT_W)'(n_f_vol) * (VOL_W+PCT_W)'(PCT_FULL);
            r_f_tag  <= {dv_tag[TAGV_W-1:VOL_W+1], n_f_vol, n_f_full, n_f_zero};
        end
    end

    logic              dp_valid;
    logic [PCT_W-1:0]  dp_quot;
    logic [TAGP_W-1:0] dp_tag;

    lctvl_div_chain #(
        .DW (VOL_W),
        .QW (PCT_W),
        .TW (TAGP_W)
    ) u_div_vpct (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_f_valid),
        .i_dividend (r_f_prod),
        .i_div      (r_usable),
        .i_tag      (r_f_tag),
        .o_valid    (dp_valid),
        .o_quot     (dp_quot),
        .o_tag      (dp_tag)
    );

    // ----------------------------------------------------------- output stage
    logic             r_out_valid;
    logic [MM_W-1:0]  r_out_level;
    logic [PCT_W-1:0] r_out_hpct;
    logic [VOL_W-1:0] r_out_vol;
    logic [PCT_W-1:0] r_out_vpct;
    logic [PCT_W-1:0] n_out_vpct;

    // Saturate the volume percentage
    always_comb begin
        if (dp_tag[1]) begin
            n_out_vpct = PCT_FULL;
        end else if (dp_tag[0]) begin
            n_out_vpct = '0;
        end else begin
            n_out_vpct = dp_quot;
        end
    end

    // Advance the pipeline unless a result beat is held
    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_level <= dp_tag[TAGP_W-1:PCT_W+VOL_W+2];
            r_out_hpct  <= dp_tag[PCT_W+VOL_W+1:VOL_W+2];
            r_out_vol   <= dp_tag[VOL_W+1:2];
            r_out_vpct  <= n_out_vpct;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_level_mm         = r_out_level;
    assign o_height_tenth_pct = r_out_hpct;
    assign o_volume_l         = r_out_vol;
    assign o_volume_tenth_pct = r_out_vpct;

endmodule
